FILE: hw/rtl/tak_pkg.sv
// ----------------------------------------------------------------------------
// tak_pkg: shared types, constants and helpers of the tilt Kalman filter
// Holds the sequencer states, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package tak_pkg;

  localparam int WIDE_W  = 68;   // working width of the datapath
  localparam int DVD_W   = 56;   // divider dividend / quotient width
  localparam int DVS_W   = 33;   // divider divisor width
  localparam int FRAC_Q  = 24;   // Q8.24 fraction bits
  localparam int MS_PER_S = 1000;
  localparam int HALF_MS  = MS_PER_S / 2;
  // floor(2^42 / 1000): reciprocal of the ms divisor for a 10-bit shifted
  // dividend and a 32-bit shifted product
  localparam logic [33:0] RECIP_MS = 34'd4398046511;

  typedef enum logic [1:0] {
    REG_ANGLE_NOISE = 2'd0,
    REG_BIAS_NOISE  = 2'd1,
    REG_MEAS_NOISE  = 2'd2,
    REG_LOOP_MS     = 2'd3
  } tak_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DT_MUL,
    ST_DT_GO,
    ST_DT_DIV,
    ST_DT_WB,
    ST_CORR,
    ST_G_GO,
    ST_G_DIV,
    ST_G_WB,
    ST_Q_MUL,
    ST_Q_WB,
    ST_OUT
  } tak_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tak_div_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh7FFFFFFF);
    lo = -WIDE_W'(64'sh80000000);
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh7FFFFFFF);
    lo = -WIDE_W'(64'sh80000000);
    return (v > hi) || (v < lo);
  endfunction

  function automatic logic signed [WIDE_W-1:0] sx68(input logic signed [31:0] v);
    return {{(WIDE_W-32){v[31]}}, v};
  endfunction

endpackage

FILE: hw/rtl/tak_in_if.sv
// ----------------------------------------------------------------------------
// tak_in_if: sample channel
// Carries one accelerometer angle and one gyro rate per transaction.
// ----------------------------------------------------------------------------
interface tak_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;

  modport source (output valid, output measured_angle, output gyro_rate, input ready);
  modport sink   (input valid, input measured_angle, input gyro_rate, output ready);
endinterface

FILE: hw/rtl/tak_out_if.sv
// ----------------------------------------------------------------------------
// tak_out_if: estimate channel
// Carries the corrected angle, the bias and a status flag per transaction.
// ----------------------------------------------------------------------------
interface tak_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;
  logic               status_flag;

  modport source (output valid, output angle_estimate, output bias_estimate,
                  output status_flag, input ready);
  modport sink   (input valid, input angle_estimate, input bias_estimate,
                  input status_flag, output ready);
endinterface

FILE: hw/rtl/tilt_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter: two-state tilt Kalman filter (angle, gyro bias)
// Fixed-point predict/correct step on a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per sample, measured_angle and gyro_rate (Q16.16).
//   out_ch : one transaction per sample, angle_estimate, bias_estimate and
//            status_flag (saturation or zero innovation variance).
//   cfg_*  : write port for the noise registers and loop_ms; write only
//            while the filter is idle.
// Sequence: in_ch.ready returns together with each result, so a new sample
//   is taken only after the last one has reached the output register. Five
//   dt scalings each pass through DT_MUL, DT_GO, DT_DIV and DT_WB (three
//   multiplier passes: times loop_ms, times the reciprocal of 1000, times
//   1000 for the remainder fix-up). Two gains run on the one-bit-per-cycle
//   divider, and six update products each take Q_MUL and Q_WB. With zero
//   innovation variance the gains are skipped. in_ch.ready is high only in idle.
// Reset: state and covariance clear to zero, registers take their defaults.
// Stall: the result sits in an output register; the next sample is taken
//   while it waits, and its result is held back until out_ch.ready.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter (
  input  logic        clk,
  input  logic        rst_n,
  tak_in_if.sink      in_ch,
  tak_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [30:0] cfg_wdata
);
  localparam int W = tak_pkg::WIDE_W;

  // configuration registers
  logic [30:0] apn_r, bpn_r, mn_r;
  logic [9:0]  loop_ms_r;

  // sequencer and filter state
  tak_pkg::tak_state_t state_r, state_nxt;
  logic [2:0]          job_r, job_nxt;
  logic signed [31:0]  meas_r, meas_nxt, rate_r, rate_nxt;
  logic signed [31:0]  angle_r, angle_nxt, bias_r, bias_nxt;
  logic signed [31:0]  aa_r, aa_nxt, ab_r, ab_nxt, ba_r, ba_nxt, bb_r, bb_nxt;
  logic signed [31:0]  angp_r, angp_nxt, p00_r, p00_nxt, p01_r, p01_nxt;
  logic signed [31:0]  p10_r, p10_nxt, p11_r, p11_nxt;
  logic signed [31:0]  y_r, y_nxt, k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [33:0]  s_r, s_nxt;
  logic                neg_r, neg_nxt;
  logic                flag_r, flag_nxt;
  logic [43:0]         dt_n_r, dt_n_nxt;
  logic [32:0]         dt_q_r, dt_q_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic signed [31:0]  out_angle_r, out_angle_nxt, out_bias_r, out_bias_nxt;
  logic                out_flag_r, out_flag_nxt;

  // shared units
  logic signed [33:0]               mul_a, mul_b;
  logic signed [W-1:0]              mul_p;
  logic                             div_start;
  logic [tak_pkg::DVD_W-1:0]        div_dvd;
  logic [tak_pkg::DVS_W-1:0]        div_dvs;
  logic [tak_pkg::DVD_W-1:0]        div_q;
  tak_pkg::tak_div_sts_t            div_sts;

  // scratch
  logic signed [33:0]  x, xmag, smag;
  logic signed [32:0]  pmag;
  logic signed [31:0]  pg, ksel, osel;
  logic signed [W-1:0] d, base, sum, pmag68, rnd;
  logic [W-1:0]        rmag;
  logic [43:0]         dt_rem;
  logic [2:0]          dt_fix;
  logic [32:0]         dt_qc;

  tak_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  tak_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quot     (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apn_r     <= 31'd167772;
      bpn_r     <= 31'd5033;
      mn_r      <= 31'd167772;
      loop_ms_r <= 10'd20;
    end else if (cfg_we) begin
      unique case (tak_pkg::tak_reg_t'(cfg_idx))
        tak_pkg::REG_ANGLE_NOISE: apn_r     <= cfg_wdata;
        tak_pkg::REG_BIAS_NOISE:  bpn_r     <= cfg_wdata;
        tak_pkg::REG_MEAS_NOISE:  mn_r      <= cfg_wdata;
        tak_pkg::REG_LOOP_MS:     loop_ms_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;  job_nxt = job_r;
    meas_nxt = meas_r;    rate_nxt = rate_r;
    angle_nxt = angle_r;  bias_nxt = bias_r;
    aa_nxt = aa_r; ab_nxt = ab_r; ba_nxt = ba_r; bb_nxt = bb_r;
    angp_nxt = angp_r; p00_nxt = p00_r; p01_nxt = p01_r;
    p10_nxt = p10_r; p11_nxt = p11_r;
    y_nxt = y_r; k0_nxt = k0_r; k1_nxt = k1_r; s_nxt = s_r;
    neg_nxt = neg_r; flag_nxt = flag_r;
    dt_n_nxt = dt_n_r; dt_q_nxt = dt_q_r;
    out_valid_nxt = out_valid_r;
    out_angle_nxt = out_angle_r; out_bias_nxt = out_bias_r; out_flag_nxt = out_flag_r;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_dvd = '0; div_dvs = '0;
    base = '0; sum = '0; d = '0; rnd = '0; rmag = '0; pmag68 = '0;
    dt_rem = '0; dt_fix = '0; dt_qc = '0;

    // drop the output once the receiver takes it
    if (out_ch.ready) out_valid_nxt = 1'b0;

    // dt operand of the current prediction job
    case (job_r)
      3'd0:    x = {{2{rate_r[31]}}, rate_r} - {{2{bias_r[31]}}, bias_r};
      3'd1:    x = $signed({3'b000, apn_r}) - {{2{ab_r[31]}}, ab_r}
                   - {{2{ba_r[31]}}, ba_r};
      3'd2,
      3'd3:    x = {{2{bb_r[31]}}, bb_r};
      default: x = $signed({3'b000, bpn_r});
    endcase
    xmag = x[33] ? -x : x;

    // gain numerator and divisor magnitudes
    pg   = job_r[0] ? p10_r : p00_r;
    pmag = pg[31] ? -{pg[31], pg} : {pg[31], pg};
    smag = s_r[33] ? -s_r : s_r;

    // operands of the current update product
    case (job_r)
      3'd0:    begin ksel = k0_r; osel = y_r;   end
      3'd1:    begin ksel = k1_r; osel = y_r;   end
      3'd2:    begin ksel = k0_r; osel = p00_r; end
      3'd3:    begin ksel = k0_r; osel = p01_r; end
      3'd4:    begin ksel = k1_r; osel = p00_r; end
      default: begin ksel = k1_r; osel = p01_r; end
    endcase

    unique case (state_r)
      tak_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          meas_nxt  = in_ch.measured_angle;
          rate_nxt  = in_ch.gyro_rate;
          flag_nxt  = 1'b0;
          job_nxt   = '0;
          state_nxt = tak_pkg::ST_DT_MUL;
        end
      end
      tak_pkg::ST_DT_MUL: begin
        // magnitude times loop_ms; the sign is applied after rounding
        mul_a     = xmag;
        mul_b     = $signed({24'd0, loop_ms_r});
        neg_nxt   = x[33];
        state_nxt = tak_pkg::ST_DT_GO;
      end
      tak_pkg::ST_DT_GO: begin
        // add half the divisor, then multiply by the reciprocal of 1000
        dt_n_nxt  = mul_p[43:0] + 44'(tak_pkg::HALF_MS);
        mul_a     = $signed({1'b0, dt_n_nxt[42:10]});
        mul_b     = $signed(tak_pkg::RECIP_MS);
        state_nxt = tak_pkg::ST_DT_DIV;
      end
      tak_pkg::ST_DT_DIV: begin
        // quotient estimate, low by at most four; form it times 1000
        dt_q_nxt  = mul_p[64:32];
        mul_a     = $signed({1'b0, mul_p[64:32]});
        mul_b     = $signed(34'(tak_pkg::MS_PER_S));
        state_nxt = tak_pkg::ST_DT_WB;
      end
      tak_pkg::ST_DT_WB: begin
        // fix up the estimate from the remainder
        dt_rem = dt_n_r - mul_p[43:0];
        dt_fix = 3'(dt_rem >= 44'(tak_pkg::MS_PER_S))
               + 3'(dt_rem >= 44'(2 * tak_pkg::MS_PER_S))
               + 3'(dt_rem >= 44'(3 * tak_pkg::MS_PER_S))
               + 3'(dt_rem >= 44'(4 * tak_pkg::MS_PER_S));
        dt_qc  = dt_q_r + {30'd0, dt_fix};
        d = neg_r ? -$signed({35'd0, dt_qc}) : $signed({35'd0, dt_qc});
        case (job_r)
          3'd0:    base = tak_pkg::sx68(angle_r);
          3'd1:    base = tak_pkg::sx68(aa_r);
          3'd2:    base = tak_pkg::sx68(ab_r);
          3'd3:    base = tak_pkg::sx68(ba_r);
          default: base = tak_pkg::sx68(bb_r);
        endcase
        sum = (job_r == 3'd2 || job_r == 3'd3) ? base - d : base + d;
        flag_nxt = flag_r | tak_pkg::ovf32(sum);
        case (job_r)
          3'd0:    angp_nxt = tak_pkg::sat32(sum);
          3'd1:    p00_nxt  = tak_pkg::sat32(sum);
          3'd2:    p01_nxt  = tak_pkg::sat32(sum);
          3'd3:    p10_nxt  = tak_pkg::sat32(sum);
          default: p11_nxt  = tak_pkg::sat32(sum);
        endcase
        if (job_r == 3'd4) begin
          state_nxt = tak_pkg::ST_CORR;
        end else begin
          job_nxt   = job_r + 3'd1;
          state_nxt = tak_pkg::ST_DT_MUL;
        end
      end
      tak_pkg::ST_CORR: begin
        sum      = tak_pkg::sx68(meas_r) - tak_pkg::sx68(angp_r);
        y_nxt    = tak_pkg::sat32(sum);
        flag_nxt = flag_r | tak_pkg::ovf32(sum);
        s_nxt    = {{2{p00_r[31]}}, p00_r} + $signed({3'b000, mn_r});
        job_nxt  = '0;
        if (s_nxt == '0) begin
          // zero innovation variance: zero gains, keep the prediction
          k0_nxt    = '0;
          k1_nxt    = '0;
          flag_nxt  = 1'b1;
          state_nxt = tak_pkg::ST_Q_MUL;
        end else begin
          state_nxt = tak_pkg::ST_G_GO;
        end
      end
      tak_pkg::ST_G_GO: begin
        div_start = 1'b1;
        div_dvd   = {pmag[31:0], 24'd0};
        div_dvs   = smag[tak_pkg::DVS_W-1:0];
        neg_nxt   = pg[31] ^ s_r[33];
        state_nxt = tak_pkg::ST_G_DIV;
      end
      tak_pkg::ST_G_DIV: begin
        if (div_sts.done) state_nxt = tak_pkg::ST_G_WB;
      end
      tak_pkg::ST_G_WB: begin
        d = neg_r ? -$signed({12'd0, div_q}) : $signed({12'd0, div_q});
        flag_nxt = flag_r | tak_pkg::ovf32(d);
        if (job_r[0]) begin
          k1_nxt    = tak_pkg::sat32(d);
          job_nxt   = '0;
          state_nxt = tak_pkg::ST_Q_MUL;
        end else begin
          k0_nxt    = tak_pkg::sat32(d);
          job_nxt   = 3'd1;
          state_nxt = tak_pkg::ST_G_GO;
        end
      end
      tak_pkg::ST_Q_MUL: begin
        mul_a     = {{2{ksel[31]}}, ksel};
        mul_b     = {{2{osel[31]}}, osel};
        state_nxt = tak_pkg::ST_Q_WB;
      end
      tak_pkg::ST_Q_WB: begin
        // round the Q8.24 product on its magnitude, ties away from zero
        pmag68 = mul_p[W-1] ? -mul_p : mul_p;
        rmag   = (W'(pmag68) + W'(64'd1 << (tak_pkg::FRAC_Q - 1))) >> tak_pkg::FRAC_Q;
        rnd    = mul_p[W-1] ? -$signed(rmag) : $signed(rmag);
        case (job_r)
          3'd0:    base = tak_pkg::sx68(angp_r);
          3'd1:    base = tak_pkg::sx68(bias_r);
          3'd2:    base = tak_pkg::sx68(p00_r);
          3'd3:    base = tak_pkg::sx68(p01_r);
          3'd4:    base = tak_pkg::sx68(p10_r);
          default: base = tak_pkg::sx68(p11_r);
        endcase
        sum = (job_r < 3'd2) ? base + rnd : base - rnd;
        flag_nxt = flag_r | tak_pkg::ovf32(sum);
        case (job_r)
          3'd0:    angle_nxt = tak_pkg::sat32(sum);
          3'd1:    bias_nxt  = tak_pkg::sat32(sum);
          3'd2:    aa_nxt    = tak_pkg::sat32(sum);
          3'd3:    ab_nxt    = tak_pkg::sat32(sum);
          3'd4:    ba_nxt    = tak_pkg::sat32(sum);
          default: bb_nxt    = tak_pkg::sat32(sum);
        endcase
        if (job_r == 3'd5) begin
          state_nxt = tak_pkg::ST_OUT;
        end else begin
          job_nxt   = job_r + 3'd1;
          state_nxt = tak_pkg::ST_Q_MUL;
        end
      end
      tak_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = angle_r;
          out_bias_nxt  = bias_r;
          out_flag_nxt  = flag_r;
          state_nxt     = tak_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tak_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tak_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      angle_r <= '0; bias_r <= '0;
      aa_r <= '0; ab_r <= '0; ba_r <= '0; bb_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r <= angle_nxt; bias_r <= bias_nxt;
      aa_r <= aa_nxt; ab_r <= ab_nxt; ba_r <= ba_nxt; bb_r <= bb_nxt;
    end
    job_r <= job_nxt;
    meas_r <= meas_nxt; rate_r <= rate_nxt;
    angp_r <= angp_nxt; p00_r <= p00_nxt; p01_r <= p01_nxt;
    p10_r <= p10_nxt; p11_r <= p11_nxt;
    y_r <= y_nxt; k0_r <= k0_nxt; k1_r <= k1_nxt; s_r <= s_nxt;
    neg_r <= neg_nxt; flag_r <= flag_nxt;
    dt_n_r <= dt_n_nxt; dt_q_r <= dt_q_nxt;
    out_angle_r <= out_angle_nxt; out_bias_r <= out_bias_nxt; out_flag_r <= out_flag_nxt;
  end

  assign in_ch.ready           = (state_r == tak_pkg::ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.angle_estimate = out_angle_r;
  assign out_ch.bias_estimate  = out_bias_r;
  assign out_ch.status_flag    = out_flag_r;

  // the divider only runs while the sequencer waits on it
  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == tak_pkg::ST_DT_DIV || state_r == tak_pkg::ST_G_DIV))
    else $error("divider busy outside a division phase");

  // an accepted sample starts the prediction
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == tak_pkg::ST_DT_MUL))
    else $error("accepted sample did not start prediction");

  // zero innovation variance leaves zero gains for the update
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tak_pkg::ST_Q_MUL && s_r == '0) |-> (k0_r == '0 && k1_r == '0))
    else $error("nonzero gain with zero innovation variance");
endmodule

FILE: hw/rtl/tak_mul.sv
// ----------------------------------------------------------------------------
// tak_mul: shared signed multiplier
// 34 x 34 signed product, registered, ready in the cycle after its operands.
// ----------------------------------------------------------------------------
module tak_mul (
  input  logic                                clk,
  input  logic signed [33:0]                  a,
  input  logic signed [33:0]                  b,
  output logic signed [tak_pkg::WIDE_W-1:0]   p_r
);
  logic signed [tak_pkg::WIDE_W-1:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule

FILE: hw/rtl/tak_div.sv
// ----------------------------------------------------------------------------
// tak_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tak_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tak_pkg::DVD_W-1:0]         dividend,
  input  logic [tak_pkg::DVS_W-1:0]         divisor,
  output tak_pkg::tak_div_sts_t             sts,
  output logic [tak_pkg::DVD_W-1:0]         quot
);
  localparam int CNT_W = $clog2(tak_pkg::DVD_W);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [tak_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [tak_pkg::DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [tak_pkg::DVD_W-1:0]  quo_r, quo_nxt;
  logic [tak_pkg::DVS_W:0]    sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    sh       = {rem_r, quo_r[tak_pkg::DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(tak_pkg::DVD_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract where it fits
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = tak_pkg::DVS_W'(sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[tak_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[tak_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[tak_pkg::DVD_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quo_r;
endmodule

FILE: verif/tb_tilt_angle_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_angle_kalman_filter: self-checking bench for the tilt Kalman filter
// Drives accelerometer/gyro samples and register writes, predicts every
// angle and bias estimate in fixed point and compares each result field.
// ----------------------------------------------------------------------------
module tb_tilt_angle_kalman_filter;

  typedef struct {
    int ang;
    int bias;
    bit flag;
  } estimate_t;

  // Tracks the filter state and the queue of estimates still owed by the block.
  class estimate_board;
    int unsigned q_angle, q_bias, r_meas, loop_ms;
    int angle_st, bias_st, p_aa, p_ab, p_ba, p_bb;
    bit clipped;
    int errors;
    estimate_t owed[$];

    function new();
      q_angle = 167772; q_bias = 5033; r_meas = 167772; loop_ms = 20;
      angle_st = 0; bias_st = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
      errors = 0;
    endfunction

    function void set_reg(tak_pkg::tak_reg_t idx, logic [30:0] val);
      case (idx)
        tak_pkg::REG_ANGLE_NOISE: q_angle = val;
        tak_pkg::REG_BIAS_NOISE:  q_bias  = val;
        tak_pkg::REG_MEAS_NOISE:  r_meas  = val;
        tak_pkg::REG_LOOP_MS:     loop_ms = val[9:0];
      endcase
    endfunction

    function int clip32(longint v);
      if (v > 64'sh7FFFFFFF) begin
        clipped = 1;
        return 32'sh7FFFFFFF;
      end
      if (v < -64'sh80000000) begin
        clipped = 1;
        return 32'sh80000000;
      end
      return int'(v);
    endfunction

    // x * loop_ms / 1000, rounded half away from zero
    function longint scale_dt(longint x);
      longint lm;
      lm = loop_ms;
      if (x >= 0) return (x * lm + 500) / 1000;
      return -(((-x) * lm + 500) / 1000);
    endfunction

    function longint mul_q24(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return (p + (64'sd1 <<< 23)) >>> 24;
      return -((-p + (64'sd1 <<< 23)) >>> 24);
    endfunction

    // Run one predict/correct step and queue the estimate it yields.
    function void note_sample(int meas, int rate);
      int ang_p, p00, p01, p10, p11, y, k0, k1;
      longint s;
      estimate_t e;
      clipped = 0;
      e.flag = 0;
      ang_p = clip32(longint'(angle_st) + scale_dt(longint'(rate) - longint'(bias_st)));
      p00 = clip32(longint'(p_aa) + scale_dt(longint'(q_angle) - longint'(p_ab)
                                               - longint'(p_ba)));
      p01 = clip32(longint'(p_ab) - scale_dt(longint'(p_bb)));
      p10 = clip32(longint'(p_ba) - scale_dt(longint'(p_bb)));
      p11 = clip32(longint'(p_bb) + scale_dt(longint'(q_bias)));
      y = clip32(longint'(meas) - longint'(ang_p));
      s = longint'(p00) + longint'(r_meas);
      if (s == 0) begin
        k0 = 0;
        k1 = 0;
        e.flag = 1;
      end else begin
        k0 = clip32((longint'(p00) <<< 24) / s);
        k1 = clip32((longint'(p10) <<< 24) / s);
      end
      angle_st = clip32(longint'(ang_p) + mul_q24(k0, y));
      bias_st  = clip32(longint'(bias_st) + mul_q24(k1, y));
      p_aa = clip32(longint'(p00) - mul_q24(k0, p00));
      p_ab = clip32(longint'(p01) - mul_q24(k0, p01));
      p_ba = clip32(longint'(p10) - mul_q24(k1, p00));
      p_bb = clip32(longint'(p11) - mul_q24(k1, p01));
      if (clipped) e.flag = 1;
      e.ang = angle_st;
      e.bias = bias_st;
      owed.push_back(e);
    endfunction

    function void check_estimate(int ang, int bias, bit flag);
      estimate_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected estimate ang=%h bias=%h flag=%b",
                 $realtime, ang, bias, flag);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (e.ang !== ang) begin
        $display("%0t: angle_estimate exp=%h act=%h", $realtime, e.ang, ang);
        errors++;
      end
      if (e.bias !== bias) begin
        $display("%0t: bias_estimate exp=%h act=%h", $realtime, e.bias, bias);
        errors++;
      end
      if (e.flag !== flag) begin
        $display("%0t: status_flag exp=%b act=%b", $realtime, e.flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [30:0] cfg_wdata;

  tak_in_if  in_ch ();
  tak_out_if out_ch ();

  tilt_angle_kalman_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  estimate_board board = new();

  // Idle mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
  int idle_mode;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Hold off results at random in modes 2 and 3, changing only at negedge.
  always @(negedge clk) begin
    if (idle_mode >= 2) begin
      out_ch.ready <= ($urandom_range(99) >= (idle_mode == 3 ? 26 : 69));
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor both channels at the rising edge: predict on every accepted
  // sample, check on every accepted estimate.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        board.note_sample(in_ch.measured_angle, in_ch.gyro_rate);
      end
      if (out_ch.valid && out_ch.ready) begin
        board.check_estimate(out_ch.angle_estimate, out_ch.bias_estimate,
                             out_ch.status_flag);
      end
    end
  end

  // Offer one sample; idle first when the mode asks, then hold valid until
  // the transaction goes through.
  task automatic send_sample(int meas, int rate);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 69 : (idle_mode == 3 ? 26 : 0);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.measured_angle <= meas;
    in_ch.gyro_rate <= rate;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every owed estimate has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(tak_pkg::tak_reg_t idx, logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [30:0] qa, logic [30:0] qb, logic [30:0] rm,
                           logic [30:0] lm);
    write_reg(tak_pkg::REG_ANGLE_NOISE, qa);
    write_reg(tak_pkg::REG_BIAS_NOISE, qb);
    write_reg(tak_pkg::REG_MEAS_NOISE, rm);
    write_reg(tak_pkg::REG_LOOP_MS, lm);
  endtask

  function automatic logic [30:0] pick_noise();
    case ($urandom_range(3))
      0: return 31'd0;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(0, 1 << 20));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_loop();
    case ($urandom_range(3))
      0: return 31'd0;
      1: return 31'd1023;
      default: return 31'($urandom_range(1, 1023));
    endcase
  endfunction

  initial begin
    int meas;
    int rate;
    idle_mode = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = tak_pkg::REG_ANGLE_NOISE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.measured_angle = '0;
    in_ch.gyro_rate = '0;
    out_ch.ready = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero innovation variance: all noises zero from a cleared covariance.
    write_all(31'd0, 31'd0, 31'd0, 31'd20);
    send_sample(32'sh0001_0000, 32'sh0000_8000);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();

    // Extremes of the fields at the largest period and at zero period.
    write_all(31'h7FFFFFFF, 31'h7FFFFFFF, 31'd167772, 31'd1023);
    send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000, 32'sh8000_0000);
    send_sample(32'sh0000_0000, 32'sh0000_0000);
    send_sample(-32'sd1, 32'sh0000_0001);
    drain();
    write_all(31'd167772, 31'd5033, 31'h7FFFFFFF, 31'd0);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(32'sh0000_0000, 32'sh5555_5555);
    send_sample(32'shAAAA_AAAA, -32'sd1);
    drain();

    // Nominal settings with a slowly moving tilt.
    write_all(31'd167772, 31'd5033, 31'd167772, 31'd1);
    for (int i = 0; i < 8; i++) begin
      send_sample(i * 32'sh0002_0000, 32'sh0001_0000 - i * 32'sh0000_4000);
    end
    drain();

    // Random phases; the idle mode cycles so every mix is covered twice.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_all(31'd167772, 31'd5033, 31'd167772, 31'd20);
      end else begin
        write_all(pick_noise(), pick_noise(), pick_noise(), pick_loop());
      end
      idle_mode = ph % 4;
      for (int i = 0; i < 235; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            // realistic: within about 20 degrees and 100 degrees per second
            meas = $urandom_range(0, 2621440) - 1310720;
            rate = $urandom_range(0, 13107200) - 6553600;
          end
          6, 7, 8: begin
            meas = $urandom;
            rate = $urandom;
          end
          default: begin
            meas = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            rate = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          end
        endcase
        send_sample(meas, rate);
      end
      drain();
    end

    idle_mode = 0;
    repeat (500) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Abort a hung run well past the slowest legal completion.
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
